@@ hdl/sct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg
// Shared widths, constants, state encoding and the command and status
// bundles that join the controller and the datapath of the composite test.
// ----------------------------------------------------------------------------
package sct_pkg;

    // width of the number under test
    localparam int NUM_W     = 32;
    // numbers below 2**SMALL_W are classified from a constant table
    localparam int SMALL_W   = 6;
    localparam int WIDE_W    = (NUM_W > SMALL_W) ? NUM_W : SMALL_W;
    // bit position and step counters
    localparam int CNT_W     = (NUM_W > 2) ? $clog2(NUM_W) : 1;
    // width of the modular reduction sum (2*acc + a < 3*n)
    localparam int SUM_W     = NUM_W + 2;

    // witness bases: together they decide primality for every n < 4759123141
    localparam int BASE_CNT   = 3;
    localparam int BASE_IDX_W = 2;
    localparam logic [BASE_IDX_W-1:0] BASE_LAST = BASE_IDX_W'(BASE_CNT - 1);

    // bit k set when k is prime, for k below 2**SMALL_W
    localparam logic [(1 << SMALL_W)-1:0] SMALL_PRIMES = 64'h2820_8A20_A08A_28AC;

    function automatic logic [NUM_W-1:0] base_value(input logic [BASE_IDX_W-1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'd2;
            2'd1:    val = 8'd7;
            2'd2:    val = 8'd61;
            default: val = 8'd2;
        endcase
        return NUM_W'(val);
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_STRIP,
        ST_BASE_INIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_EXP_NEXT,
        ST_CHECK_FIRST,
        ST_CHECK_LOOP,
        ST_CHK_GO,
        ST_CHK_WAIT,
        ST_BASE_NEXT,
        ST_FINISH
    } sct_state_t;

    typedef struct packed {
        logic load;       // capture a new number
        logic strip;      // drop one trailing zero of n-1
        logic base_init;  // start a new witness base
        logic mm_start;   // launch a modular multiply into x
        logic mm_base;    // multiply x by the base instead of squaring
        logic ebit_dec;   // advance to the next exponent bit
        logic sq_dec;     // consume one extra squaring
        logic base_inc;   // move to the next witness base
    } sct_cmd_t;

    typedef struct packed {
        logic below_table; // number below the table limit
        logic prime_small; // table verdict for a number below the limit
        logic even;
        logic d_lsb;       // odd part of n-1 reached when set
        logic d_bit;       // current exponent bit
        logic ebit_zero;   // last exponent bit processed
        logic mm_done;     // modular multiply finished, x takes the result
        logic x_one;
        logic x_nm1;
        logic sq_zero;     // no squarings left for this base
        logic base_last;
    } sct_sts_t;

endpackage

@@ hdl/sct_modmul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_modmul
// Bit-serial modular multiplier: a * b mod n, one multiplier bit per cycle,
// MSB first, with the running residue kept below n at every step.
// ----------------------------------------------------------------------------
module sct_modmul
    import sct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] a,
    input  logic [NUM_W-1:0] b,
    input  logic [NUM_W-1:0] n,
    output logic             done,
    output logic [NUM_W-1:0] result
);

    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(NUM_W - 1);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [NUM_W-1:0] acc_reg,   acc_next;
    logic [NUM_W-1:0] a_reg,     a_next;
    logic [NUM_W-1:0] b_reg,     b_next;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] n1;
    logic [SUM_W-1:0] n2;
    logic [SUM_W-1:0] reduced;

    // 2*acc + (bit ? a : 0) stays below 3n; subtract n or 2n to bring it back
    always_comb
    begin
        n1  = SUM_W'(n);
        n2  = SUM_W'(n) << 1;
        sum = (SUM_W'(acc_reg) << 1) + (b_reg[NUM_W-1] ? SUM_W'(a_reg) : '0);
        if (sum >= n2)
        begin
            reduced = sum - n2;
        end
        else if (sum >= n1)
        begin
            reduced = sum - n1;
        end
        else
        begin
            reduced = sum;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
        end
        else if (busy_reg)
        begin
            acc_next = NUM_W'(reduced);
            b_next   = b_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

@@ hdl/sct_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_datapath
// Holds the number, the odd part of n-1, the running power x and the loop
// counters; hosts the modular multiplier and reports status to the controller.
// ----------------------------------------------------------------------------
module sct_datapath
    import sct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [NUM_W-1:0] number,
    input  sct_cmd_t         cmd,
    output sct_sts_t         sts
);

    logic [NUM_W-1:0]      n_reg,        n_next;
    logic [NUM_W-1:0]      nm1_reg,      nm1_next;
    logic [NUM_W-1:0]      d_reg,        d_next;
    logic [NUM_W-1:0]      x_reg,        x_next;
    logic [CNT_W-1:0]      s_reg,        s_next;
    logic [CNT_W-1:0]      ebit_reg,     ebit_next;
    logic [CNT_W-1:0]      sq_reg,       sq_next;
    logic [BASE_IDX_W-1:0] base_idx_reg, base_idx_next;

    logic [WIDE_W-1:0] n_wide;
    logic [NUM_W-1:0]  base;
    logic [NUM_W-1:0]  mm_a;
    logic              mm_done;
    logic [NUM_W-1:0]  mm_result;

    assign n_wide = WIDE_W'(n_reg);
    assign base   = base_value(base_idx_reg);
    assign mm_a   = cmd.mm_base ? base : x_reg;

    sct_modmul u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mm_start),
        .a      (mm_a),
        .b      (x_reg),
        .n      (n_reg),
        .done   (mm_done),
        .result (mm_result)
    );

    always_comb
    begin
        n_next        = n_reg;
        nm1_next      = nm1_reg;
        d_next        = d_reg;
        x_next        = x_reg;
        s_next        = s_reg;
        ebit_next     = ebit_reg;
        sq_next       = sq_reg;
        base_idx_next = base_idx_reg;

        if (cmd.load)
        begin
            n_next        = number;
            nm1_next      = number - 1'b1;
            d_next        = number - 1'b1;
            s_next        = '0;
            base_idx_next = '0;
        end
        if (cmd.strip)
        begin
            d_next = d_reg >> 1;
            s_next = s_reg + 1'b1;
        end
        if (cmd.base_init)
        begin
            x_next    = NUM_W'(1);
            ebit_next = CNT_W'(NUM_W - 1);
            sq_next   = s_reg - 1'b1;
        end
        if (mm_done)
        begin
            x_next = mm_result;
        end
        if (cmd.ebit_dec)
        begin
            ebit_next = ebit_reg - 1'b1;
        end
        if (cmd.sq_dec)
        begin
            sq_next = sq_reg - 1'b1;
        end
        if (cmd.base_inc)
        begin
            base_idx_next = base_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg        <= '0;
            ebit_reg     <= '0;
            sq_reg       <= '0;
            base_idx_reg <= '0;
        end
        else
        begin
            s_reg        <= s_next;
            ebit_reg     <= ebit_next;
            sq_reg       <= sq_next;
            base_idx_reg <= base_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        nm1_reg <= nm1_next;
        d_reg   <= d_next;
        x_reg   <= x_next;
    end

    always_comb
    begin
        sts.below_table = (n_wide >> SMALL_W) == '0;
        sts.prime_small = SMALL_PRIMES[n_wide[SMALL_W-1:0]];
        sts.even        = ~n_reg[0];
        sts.d_lsb       = d_reg[0];
        sts.d_bit       = d_reg[ebit_reg];
        sts.ebit_zero   = (ebit_reg == '0);
        sts.mm_done     = mm_done;
        sts.x_one       = (x_reg == NUM_W'(1));
        sts.x_nm1       = (x_reg == nm1_reg);
        sts.sq_zero     = (sq_reg == '0);
        sts.base_last   = (base_idx_reg == BASE_LAST);
    end

endmodule

@@ hdl/sct_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_ctrl
// Sequencer for the composite test: classifies trivial cases, then steps the
// datapath through one strong-probable-prime round per witness base, and
// holds the verdict in the output register until it is taken.
// ----------------------------------------------------------------------------
module sct_ctrl
    import sct_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     number_valid,
    output logic     number_ready,
    output logic     result_valid,
    input  logic     result_ready,
    output logic     is_composite,
    input  sct_sts_t sts,
    output sct_cmd_t cmd
);

    sct_state_t state_reg, state_next;
    logic       verdict_reg, verdict_next;
    logic       out_valid_reg, out_valid_next;
    logic       is_composite_reg, is_composite_next;
    logic       finish_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            verdict_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            verdict_reg   <= verdict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_composite_reg <= is_composite_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        verdict_next      = verdict_reg;
        cmd               = '0;
        number_ready      = 1'b0;
        finish_fire       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                number_ready = 1'b1;
                if (number_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                if (sts.below_table)
                begin
                    verdict_next = ~sts.prime_small;
                    state_next   = ST_FINISH;
                end
                else if (sts.even)
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                if (sts.d_lsb)
                begin
                    state_next = ST_BASE_INIT;
                end
                else
                begin
                    cmd.strip = 1'b1;
                end
            end
            ST_BASE_INIT:
            begin
                cmd.base_init = 1'b1;
                state_next    = ST_SQ_GO;
            end
            ST_SQ_GO:
            begin
                cmd.mm_start = 1'b1;
                state_next   = ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                if (sts.mm_done)
                begin
                    state_next = sts.d_bit ? ST_MUL_GO : ST_EXP_NEXT;
                end
            end
            ST_MUL_GO:
            begin
                cmd.mm_start = 1'b1;
                cmd.mm_base  = 1'b1;
                state_next   = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (sts.mm_done)
                begin
                    state_next = ST_EXP_NEXT;
                end
            end
            ST_EXP_NEXT:
            begin
                if (sts.ebit_zero)
                begin
                    state_next = ST_CHECK_FIRST;
                end
                else
                begin
                    cmd.ebit_dec = 1'b1;
                    state_next   = ST_SQ_GO;
                end
            end
            ST_CHECK_FIRST:
            begin
                if (sts.x_one || sts.x_nm1)
                begin
                    state_next = ST_BASE_NEXT;
                end
                else
                begin
                    state_next = ST_CHECK_LOOP;
                end
            end
            ST_CHECK_LOOP:
            begin
                if (sts.x_nm1)
                begin
                    state_next = ST_BASE_NEXT;
                end
                else if (sts.sq_zero)
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    state_next = ST_CHK_GO;
                end
            end
            ST_CHK_GO:
            begin
                cmd.mm_start = 1'b1;
                cmd.sq_dec   = 1'b1;
                state_next   = ST_CHK_WAIT;
            end
            ST_CHK_WAIT:
            begin
                if (sts.mm_done)
                begin
                    state_next = ST_CHECK_LOOP;
                end
            end
            ST_BASE_NEXT:
            begin
                if (sts.base_last)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cmd.base_inc = 1'b1;
                    state_next   = ST_BASE_INIT;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result_ready)
                begin
                    finish_fire = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg && !result_ready;
        is_composite_next = is_composite_reg;
        if (finish_fire)
        begin
            out_valid_next    = 1'b1;
            is_composite_next = verdict_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign is_composite = is_composite_reg;

endmodule

@@ hdl/staircase_composite_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staircase_composite_test
// Classifies one unsigned number per transaction as composite (1) or not (0).
// ----------------------------------------------------------------------------
// Each accepted number yields exactly one result transaction. The verdict is
// 1 for zero, one, every even number other than two and every odd composite,
// and 0 for primes. Numbers below 64 are decided from a constant table and
// even numbers at once, without the multiplier. Odd numbers of 64 and above
// are decided by strong-probable-prime rounds to the bases 2, 7 and 61, which
// settle primality exactly for every 32-bit value. Those rounds run on one
// bit-serial modular multiplier; a round costs NUM_W squarings, one multiply
// per set bit of the odd part of n-1, plus up to s-1 further squarings where
// 2^s is the largest power of two dividing n-1. A composite usually stops
// after the first base. One number is worked on at a time; number_ready is
// high only while the block is idle. A finished verdict waits in the output
// register, and the next number may be accepted while it does.
// ----------------------------------------------------------------------------
module staircase_composite_test
    import sct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             number_valid,
    output logic             number_ready,
    input  logic [NUM_W-1:0] number,
    output logic             result_valid,
    input  logic             result_ready,
    output logic             is_composite
);

    // command and status bundles between the sequencer and the datapath
    sct_cmd_t cmd;
    sct_sts_t sts;

    // sequencer: walks classification, factor-of-two stripping, the modular
    // exponentiation per base and the squaring chain; owns the output register
    sct_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_valid (number_valid),
        .number_ready (number_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_composite (is_composite),
        .sts          (sts),
        .cmd          (cmd)
    );

    // datapath: operand registers, counters and the modular multiplier
    sct_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number),
        .cmd    (cmd),
        .sts    (sts)
    );

`ifndef SYNTHESIS
    // one number at a time: acceptance closes the input until the verdict is out
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (number_valid && number_ready) |=> !number_ready)
        else $error("number accepted while a transaction is in progress");

    // a multiply never reports completion the cycle after it is launched
    a_mm_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mm_start |=> !sts.mm_done)
        else $error("modular multiply finished too early");

    // a fresh verdict only appears at the end of work on a number
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(number_ready))
        else $error("result raised without a transaction in progress");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the composite test: feeds numbers over the valid/ready
// input channel and checks every verdict against a local model or a row's fixed verdict.
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, the trivial verdicts (zero,
// one, two, even numbers), the table limit of the small-number path, prime
// powers, Carmichael numbers and strong pseudoprimes. A random part follows,
// mixing plain random values, primes, products of two odd factors, squares
// and small numbers. The run walks three handshake phases: a lazy result
// consumer, then a lazy number source, then both sides at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    import sct_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_PER_PHASE = 27;
    localparam int PHASE_COUNT   = 3;
    // allow every number to take as long as an odd prime near 2**32,
    // several times over
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int DRAIN_CYCLES  = 32;
    localparam int DIRECTED_COUNT = 25;
    localparam int TRICKY_COUNT  = 20;

    // how a directed row is checked: a verdict read off at a glance, or the model
    typedef enum logic [1:0] {
        ROW_PRIME,
        ROW_COMPOSITE,
        ROW_PREDICT
    } row_kind_t;

    typedef struct packed {
        logic [NUM_W-1:0] value;
        row_kind_t        kind;
    } directed_row_t;

    typedef struct packed {
        logic [NUM_W-1:0] value;
        logic             verdict;
    } pending_verdict_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             number_valid = 1'b0;
    logic             number_ready;
    logic [NUM_W-1:0] number = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    logic             is_composite;

    pending_verdict_t verdicts_due[$];
    directed_row_t    directed_rows [DIRECTED_COUNT];
    logic [NUM_W-1:0] tricky_numbers [TRICKY_COUNT];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int cycle_count       = 0;
    int error_count       = 0;
    int numbers_sent      = 0;
    int verdicts_checked  = 0;
    int composites_seen   = 0;

    staircase_composite_test uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_valid (number_valid),
        .number_ready (number_ready),
        .number       (number),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_composite (is_composite)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // The witness rounds to the bases 2, 7 and 61 flag an odd n >= 3 exactly
    // when it has a proper divisor: a prime power, whatever its exponent, and
    // any other composite below 2**32 fail at least one of the three rounds,
    // while a prime survives all three. Numbers below the table limit are read
    // off the table instead. So predict with plain trial division by odd
    // divisors up to the root.
    function automatic logic composite_verdict(input logic [NUM_W-1:0] value);
        longint unsigned n;
        longint unsigned divisor;
        n = longint'(value);
        if (n == 2)
            return 1'b0;
        if (n < 2 || value[0] == 1'b0)
            return 1'b1;
        for (divisor = 3; divisor * divisor <= n; divisor += 2)
        begin
            if (n % divisor == 0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Draw one random number, biased toward the shapes that stress the block.
    function automatic logic [NUM_W-1:0] random_number();
        int unsigned      pick;
        logic [NUM_W-1:0] value;
        logic [NUM_W-1:0] factor_a;
        logic [NUM_W-1:0] factor_b;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            // plain random odd value
            value = $urandom | 1;
        end
        else if (pick < 45)
        begin
            // next prime at or above a random odd start; clamp to the top prime
            value = $urandom | 1;
            if (value > 32'hFFFF_FFFB)
                value = 32'hFFFF_FFFB;
            while (composite_verdict(value))
                value = value + 2;
        end
        else if (pick < 60)
        begin
            // product of two odd factors, sometimes a square
            factor_a = $urandom_range(65535, 3) | 1;
            factor_b = $urandom_range(65535, 3) | 1;
            if ($urandom_range(3) == 0)
                factor_b = factor_a;
            value = factor_a * factor_b;
        end
        else if (pick < 72)
        begin
            // around the small-number table limit
            value = $urandom_range(130);
        end
        else if (pick < 80)
        begin
            value = $urandom & ~32'd1;
        end
        else if (pick < 92)
        begin
            value = tricky_numbers[$urandom_range(TRICKY_COUNT - 1)];
        end
        else
        begin
            value = $urandom;
        end
        return value;
    endfunction

    // Present one number and hold it until the block takes it. Idle cycles
    // drop valid first; without idling valid stays high from the last transaction.
    task automatic send_number(input logic [NUM_W-1:0] value, input row_kind_t kind);
        pending_verdict_t due;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            number_valid <= 1'b0;
            @(posedge clk);
        end
        number_valid <= 1'b1;
        number       <= value;
        @(posedge clk);
        while (!number_ready)
            @(posedge clk);
        due.value = value;
        case (kind)
            ROW_PRIME:     due.verdict = 1'b0;
            ROW_COMPOSITE: due.verdict = 1'b1;
            default:       due.verdict = composite_verdict(value);
        endcase
        verdicts_due.push_back(due);
        numbers_sent++;
    endtask

    // Stimulus: reset, then three handshake phases; the directed table runs first.
    initial
    begin
        int phase;
        int row;
        int item;
        directed_rows = '{
            '{32'd0,          ROW_COMPOSITE},
            '{32'd1,          ROW_COMPOSITE},
            '{32'd2,          ROW_PRIME},
            '{32'd3,          ROW_PRIME},
            '{32'd4,          ROW_COMPOSITE},
            '{32'd9,          ROW_PREDICT},
            '{32'd25,         ROW_PREDICT},
            '{32'd27,         ROW_PREDICT},
            '{32'd61,         ROW_PREDICT},
            '{32'd63,         ROW_PREDICT},
            '{32'd64,         ROW_COMPOSITE},
            '{32'd65,         ROW_PREDICT},
            '{32'd67,         ROW_PREDICT},
            '{32'd561,        ROW_PREDICT},
            '{32'd2047,       ROW_PREDICT},
            '{32'd3215031751, ROW_PREDICT},
            '{32'd1162261467, ROW_PREDICT},
            '{32'd3486784401, ROW_PREDICT},
            '{32'd4292870399, ROW_PREDICT},
            '{32'd4293001441, ROW_PREDICT},
            '{32'd2147483647, ROW_PREDICT},
            '{32'd4294967291, ROW_PREDICT},
            '{32'd4294967294, ROW_COMPOSITE},
            '{32'd4294967295, ROW_PREDICT},
            '{32'h8000_0000,  ROW_COMPOSITE}
        };
        // Carmichael numbers, strong pseudoprimes, prime powers and edge primes
        tricky_numbers = '{
            32'd561, 32'd1105, 32'd1729, 32'd41041, 32'd825265,
            32'd2047, 32'd3277, 32'd4033, 32'd4681, 32'd8321,
            32'd25326001, 32'd3215031751, 32'd3234846615, 32'd1220703125,
            32'd1977326743, 32'd3486784401, 32'd65537, 32'd2147483647,
            32'd4294967291, 32'd4294967295
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct   = 13;
                    receiver_idle_pct = 70;
                end
                1:
                begin
                    sender_idle_pct   = 70;
                    receiver_idle_pct = 13;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            if (phase == 0)
            begin
                for (row = 0; row < DIRECTED_COUNT; row++)
                    send_number(directed_rows[row].value, directed_rows[row].kind);
            end
            for (item = 0; item < RANDOM_PER_PHASE; item++)
                send_number(random_number(), ROW_PREDICT);
        end
        number_valid <= 1'b0;

        // drain the outstanding verdicts, then watch for stray results
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d verdicts over %0d numbers (%0d composite), directed and random,",
                 verdicts_checked, numbers_sent, composites_seen);
        $display("across lazy-consumer, lazy-source and full-rate handshake phases.");
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side: check every accepted transaction, then toss the coin for ready.
    always @(posedge clk)
    begin
        pending_verdict_t due;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, is_composite %0b",
                             $time, is_composite);
                    error_count++;
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    verdicts_checked++;
                    if (due.verdict)
                        composites_seen++;
                    if (is_composite !== due.verdict)
                    begin
                        $display("%0t: is_composite mismatch for %0d: expected %0b, actual %0b",
                                 $time, due.value, due.verdict, is_composite);
                        error_count++;
                    end
                end
            end
            result_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d verdicts still due",
                     cycle_count, verdicts_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
